@@ src/kmes_pkg.sv @@
// Package for the key matrix and encoder scanner.
// Holds field widths, row codes and quadrature patterns; depends on nothing.
`default_nettype none

package kmes_pkg;

   // Field widths of the scan channels.
   localparam int COL_WIDTH  = 5;
   localparam int KEY_WIDTH  = 11;
   localparam int ROW_WIDTH  = 2;
   localparam int STEP_WIDTH = 16;
   localparam int HIST_WIDTH = 4;

   // Default width of the internal step counters.
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Row codes. The fourth code is never reached and is scanned like the top row.
   localparam logic [ROW_WIDTH-1:0] ROW_TOP     = 2'd0;
   localparam logic [ROW_WIDTH-1:0] ROW_BOTTOM  = 2'd1;
   localparam logic [ROW_WIDTH-1:0] ROW_ENCODER = 2'd2;

   // Quadrature history patterns that mark one detent.
   localparam logic [HIST_WIDTH-1:0] PATTERN_RIGHT = 4'b1011;
   localparam logic [HIST_WIDTH-1:0] PATTERN_LEFT  = 4'b0111;

   // Position of the encoder push key in the key word.
   localparam int PUSH_KEY_BIT = 10;

endpackage

`default_nettype wire

@@ src/kmes_if.sv @@
// Channel interfaces for the key matrix and encoder scanner.
// Sample and result channels with valid/ready; depends on kmes_pkg.
`default_nettype none

interface kmes_req_if;
   logic                               valid;
   logic                               ready;
   logic [kmes_pkg::COL_WIDTH-1:0]     column_bits;
   logic                               clear_latches;

   modport source (output valid, column_bits, clear_latches, input ready);
   modport sink   (input valid, column_bits, clear_latches, output ready);
endinterface

interface kmes_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [kmes_pkg::ROW_WIDTH-1:0]     scanned_row;
   logic [kmes_pkg::ROW_WIDTH-1:0]     next_row;
   logic [kmes_pkg::KEY_WIDTH-1:0]     key_levels;
   logic [kmes_pkg::KEY_WIDTH-1:0]     pressed_mask;
   logic [kmes_pkg::KEY_WIDTH-1:0]     released_mask;
   logic [kmes_pkg::STEP_WIDTH-1:0]    right_steps;
   logic [kmes_pkg::STEP_WIDTH-1:0]    left_steps;

   modport source (output valid, scanned_row, next_row, key_levels, pressed_mask,
                   released_mask, right_steps, left_steps, input ready);
   modport sink   (input valid, scanned_row, next_row, key_levels, pressed_mask,
                   released_mask, right_steps, left_steps, output ready);
endinterface

`default_nettype wire

@@ src/key_matrix_and_encoder_scanner.sv @@
// Key matrix and rotary encoder scanner, top level.
// Depends on kmes_pkg and on the channel interfaces in kmes_if.
//
// Usage: every transfer on req_ch is one scan tick. It carries the five column
// levels sampled while the row given by the last next_row was strobed, and a
// flag that empties the sticky press and release masks before the tick is
// applied. Rows cycle top, bottom, encoder. The top and bottom rows refresh
// ten matrix keys; the encoder row shifts two quadrature bits into a history
// and samples the push key.
// Every accepted tick produces exactly one registered transfer on rsp_ch, showing
// the state after that tick: the row scanned, the row to
// strobe next, the key levels, both sticky masks and the low 16 bits of the
// wrapping step counters. A new tick is accepted in every cycle as long as the
// result register is empty or is being emptied in the same cycle, so the
// sustained rate is one tick per clock, set by the single result register.
// When the receiver stalls, the result holds and req_ch.ready drops; the
// scanner state is frozen until the pending result is taken.
// Synchronous reset clears all state: row back to top, keys, masks, quadrature
// history and counters to zero, and no result pending.
`default_nettype none

module key_matrix_and_encoder_scanner #(
   parameter int COUNT_WIDTH = kmes_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   kmes_req_if.sink    req_ch,
   kmes_rsp_if.source  rsp_ch
);

   // Scanner state. The result channel reads it directly, since it only
   // changes when a tick is accepted and a tick is only accepted when the
   // previous result has left.
   logic [kmes_pkg::ROW_WIDTH-1:0]  row_ff,       row_in;
   logic [kmes_pkg::ROW_WIDTH-1:0]  scanned_ff,   scanned_in;
   logic [kmes_pkg::KEY_WIDTH-1:0]  key_ff,       key_in;
   logic [kmes_pkg::KEY_WIDTH-1:0]  press_ff,     press_in;
   logic [kmes_pkg::KEY_WIDTH-1:0]  release_ff,   release_in;
   logic [kmes_pkg::HIST_WIDTH-1:0] hist_ff,      hist_in;
   logic [COUNT_WIDTH-1:0]          right_ff,     right_in;
   logic [COUNT_WIDTH-1:0]          left_ff,      left_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            accept;
   logic [kmes_pkg::COL_WIDTH-1:0]  cols;
   logic [kmes_pkg::KEY_WIDTH-1:0]  press_base;
   logic [kmes_pkg::KEY_WIDTH-1:0]  release_base;

   // The column wiring is mirrored relative to the key numbering.
   always_comb begin
      for (int i = 0; i < kmes_pkg::COL_WIDTH; i++) begin
         cols[i] = req_ch.column_bits[kmes_pkg::COL_WIDTH-1-i];
      end
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Next state of one tick.
   always_comb begin
      row_in     = row_ff;
      scanned_in = scanned_ff;
      key_in     = key_ff;
      hist_in    = hist_ff;
      right_in   = right_ff;
      left_in    = left_ff;
      press_in   = press_ff;
      release_in = release_ff;

      if (accept) begin
         unique case (row_ff)
            kmes_pkg::ROW_BOTTOM: begin
               key_in[kmes_pkg::COL_WIDTH-1:0] = cols;
               scanned_in = kmes_pkg::ROW_BOTTOM;
               row_in     = kmes_pkg::ROW_ENCODER;
            end
            kmes_pkg::ROW_ENCODER: begin
               hist_in = {hist_ff[kmes_pkg::HIST_WIDTH-3:0], cols[1:0]};
               if (hist_in == kmes_pkg::PATTERN_RIGHT) begin
                  right_in = right_ff + COUNT_WIDTH'(1);
               end
               if (hist_in == kmes_pkg::PATTERN_LEFT) begin
                  left_in = left_ff + COUNT_WIDTH'(1);
               end
               key_in[kmes_pkg::PUSH_KEY_BIT] = cols[2];
               scanned_in = kmes_pkg::ROW_ENCODER;
               row_in     = kmes_pkg::ROW_TOP;
            end
            kmes_pkg::ROW_TOP: begin
               key_in[2*kmes_pkg::COL_WIDTH-1:kmes_pkg::COL_WIDTH] = cols;
               scanned_in = kmes_pkg::ROW_TOP;
               row_in     = kmes_pkg::ROW_BOTTOM;
            end
            default: begin
               // Unreachable row code: scanned like the top row, then restart.
               key_in[2*kmes_pkg::COL_WIDTH-1:kmes_pkg::COL_WIDTH] = cols;
               scanned_in = kmes_pkg::ROW_TOP;
               row_in     = kmes_pkg::ROW_TOP;
            end
         endcase

         // A clear empties the masks first, so edges of this tick still latch.
         press_base   = req_ch.clear_latches ? '0 : press_ff;
         release_base = req_ch.clear_latches ? '0 : release_ff;
         press_in     = press_base   | (key_in & ~key_ff);
         release_in   = release_base | (key_ff & ~key_in);
      end else begin
         press_base   = press_ff;
         release_base = release_ff;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= kmes_pkg::ROW_TOP;
         scanned_ff   <= kmes_pkg::ROW_TOP;
         key_ff       <= '0;
         press_ff     <= '0;
         release_ff   <= '0;
         hist_ff      <= '0;
         right_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         scanned_ff   <= scanned_in;
         key_ff       <= key_in;
         press_ff     <= press_in;
         release_ff   <= release_in;
         hist_ff      <= hist_in;
         right_ff     <= right_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.scanned_row   = scanned_ff;
   assign rsp_ch.next_row      = row_ff;
   assign rsp_ch.key_levels    = key_ff;
   assign rsp_ch.pressed_mask  = press_ff;
   assign rsp_ch.released_mask = release_ff;

   // The result shows the low 16 bits of each counter, zero-extended if narrower.
   generate
      if (COUNT_WIDTH >= kmes_pkg::STEP_WIDTH) begin : g_steps_trunc
         assign rsp_ch.right_steps = right_ff[kmes_pkg::STEP_WIDTH-1:0];
         assign rsp_ch.left_steps  = left_ff[kmes_pkg::STEP_WIDTH-1:0];
      end else begin : g_steps_ext
         assign rsp_ch.right_steps = {{(kmes_pkg::STEP_WIDTH-COUNT_WIDTH){1'b0}}, right_ff};
         assign rsp_ch.left_steps  = {{(kmes_pkg::STEP_WIDTH-COUNT_WIDTH){1'b0}}, left_ff};
      end
   endgenerate

`ifndef ASSERT_OFF
   // The row sequence never leaves the three legal rows.
   a_row_legal: assert property (@(posedge clock) disable iff (reset)
      (row_ff == kmes_pkg::ROW_TOP || row_ff == kmes_pkg::ROW_BOTTOM ||
       row_ff == kmes_pkg::ROW_ENCODER))
      else $error("row index reached an illegal code");

   // The next row shown always follows the scanned row in the cycle.
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((scanned_ff == kmes_pkg::ROW_TOP     && row_ff == kmes_pkg::ROW_BOTTOM)  ||
          (scanned_ff == kmes_pkg::ROW_BOTTOM  && row_ff == kmes_pkg::ROW_ENCODER) ||
          (scanned_ff == kmes_pkg::ROW_ENCODER && row_ff == kmes_pkg::ROW_TOP)))
      else $error("next row does not follow scanned row");

   // Step counters only move on an encoder row tick.
   a_count_encoder_only: assert property (@(posedge clock) disable iff (reset)
      (accept && row_ff != kmes_pkg::ROW_ENCODER) |=>
         ($stable(right_ff) && $stable(left_ff)))
      else $error("step counter moved on a matrix row");

   // Without a clear, sticky masks never lose a bit.
   a_masks_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch.clear_latches) |=>
         (((press_ff & $past(press_ff)) == $past(press_ff)) &&
          ((release_ff & $past(release_ff)) == $past(release_ff))))
      else $error("sticky mask lost a bit without a clear");
`endif

endmodule

`default_nettype wire

@@ test/kmes_scan_checker.sv @@
// Result checker for the key matrix and encoder scanner testbench.
// Watches both channels, predicts every scan result, compares; needs kmes_pkg and kmes_if.
`timescale 1ns / 100ps

module kmes_scan_checker (
   input  wire        clock,
   input  wire        reset,
   kmes_req_if        req_ch,
   kmes_rsp_if        rsp_ch,
   output int         error_count,
   output int         outstanding
);

   typedef struct packed {
      logic [kmes_pkg::ROW_WIDTH-1:0]  scanned_row;
      logic [kmes_pkg::ROW_WIDTH-1:0]  next_row;
      logic [kmes_pkg::KEY_WIDTH-1:0]  key_levels;
      logic [kmes_pkg::KEY_WIDTH-1:0]  pressed_mask;
      logic [kmes_pkg::KEY_WIDTH-1:0]  released_mask;
      logic [kmes_pkg::STEP_WIDTH-1:0] right_steps;
      logic [kmes_pkg::STEP_WIDTH-1:0] left_steps;
   } scan_result_type;

   // Mirror of the scanner state.
   logic [kmes_pkg::ROW_WIDTH-1:0]           row_q;
   logic [kmes_pkg::KEY_WIDTH-1:0]           keys_q;
   logic [kmes_pkg::KEY_WIDTH-1:0]           pressed_q;
   logic [kmes_pkg::KEY_WIDTH-1:0]           released_q;
   logic [kmes_pkg::HIST_WIDTH-1:0]          history_q;
   logic [kmes_pkg::COUNT_WIDTH_DEFAULT-1:0] right_count_q;
   logic [kmes_pkg::COUNT_WIDTH_DEFAULT-1:0] left_count_q;

   scan_result_type expected_scans[$];
   scan_result_type want;
   scan_result_type got;
   scan_result_type fresh;

   // Applies one scan tick to the mirrored state and returns the result it shows.
   task automatic apply_scan_tick(input logic [kmes_pkg::COL_WIDTH-1:0] raw,
                                  input logic clear, output scan_result_type res);
      logic [kmes_pkg::COL_WIDTH-1:0] cols;
      logic [kmes_pkg::KEY_WIDTH-1:0] prior;
      for (int b = 0; b < kmes_pkg::COL_WIDTH; b++) begin
         cols[b] = raw[kmes_pkg::COL_WIDTH-1-b];
      end
      if (clear) begin
         pressed_q  = '0;
         released_q = '0;
      end
      prior = keys_q;
      res.scanned_row = row_q;
      unique case (row_q)
         kmes_pkg::ROW_ENCODER: begin
            history_q = {history_q[kmes_pkg::HIST_WIDTH-3:0], cols[1:0]};
            if (history_q == kmes_pkg::PATTERN_RIGHT) right_count_q = right_count_q + 1'b1;
            if (history_q == kmes_pkg::PATTERN_LEFT)  left_count_q  = left_count_q + 1'b1;
            keys_q[kmes_pkg::PUSH_KEY_BIT] = cols[2];
            res.next_row = kmes_pkg::ROW_TOP;
         end
         kmes_pkg::ROW_BOTTOM: begin
            keys_q[kmes_pkg::COL_WIDTH-1:0] = cols;
            res.next_row = kmes_pkg::ROW_ENCODER;
         end
         kmes_pkg::ROW_TOP: begin
            keys_q[2*kmes_pkg::COL_WIDTH-1:kmes_pkg::COL_WIDTH] = cols;
            res.next_row = kmes_pkg::ROW_BOTTOM;
         end
         default: begin
            // The unused row code scans like the top row and restarts at the top.
            keys_q[2*kmes_pkg::COL_WIDTH-1:kmes_pkg::COL_WIDTH] = cols;
            res.scanned_row = kmes_pkg::ROW_TOP;
            res.next_row    = kmes_pkg::ROW_TOP;
         end
      endcase
      pressed_q  = pressed_q | (keys_q & ~prior);
      released_q = released_q | (prior & ~keys_q);
      row_q = res.next_row;
      res.key_levels    = keys_q;
      res.pressed_mask  = pressed_q;
      res.released_mask = released_q;
      res.right_steps   = right_count_q[kmes_pkg::STEP_WIDTH-1:0];
      res.left_steps    = left_count_q[kmes_pkg::STEP_WIDTH-1:0];
   endtask

   task automatic check_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_q         = kmes_pkg::ROW_TOP;
         keys_q        = '0;
         pressed_q     = '0;
         released_q    = '0;
         history_q     = '0;
         right_count_q = '0;
         left_count_q  = '0;
         expected_scans.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_scan_tick(req_ch.column_bits, req_ch.clear_latches, fresh);
            expected_scans.push_back(fresh);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.scanned_row, rsp_ch.next_row, rsp_ch.key_levels,
                    rsp_ch.pressed_mask, rsp_ch.released_mask,
                    rsp_ch.right_steps, rsp_ch.left_steps};
            if (expected_scans.size() == 0) begin
               $display("%0t: result transfer with none expected, actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_scans.pop_front();
               check_field("scanned_row", 32'(want.scanned_row), 32'(got.scanned_row));
               check_field("next_row", 32'(want.next_row), 32'(got.next_row));
               check_field("key_levels", 32'(want.key_levels), 32'(got.key_levels));
               check_field("pressed_mask", 32'(want.pressed_mask),
                           32'(got.pressed_mask));
               check_field("released_mask", 32'(want.released_mask),
                           32'(got.released_mask));
               check_field("right_steps", 32'(want.right_steps), 32'(got.right_steps));
               check_field("left_steps", 32'(want.left_steps), 32'(got.left_steps));
            end
         end
      end
      outstanding <= expected_scans.size();
   end

endmodule

@@ test/tb_top.sv @@
// Top level of the key matrix and encoder scanner testbench.
// Drives scan ticks and result stalls, gives the verdict; needs kmes_pkg, kmes_if,
// the scanner RTL and kmes_scan_checker.
`timescale 1ns / 100ps

module tb_top;

   // Generous cycle budget for about 1650 ticks, with random idle gaps on each side.
   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int          RANDOM_BLOCKS = 10;
   localparam int          BLOCK_ITEMS   = 163;

   logic        clock;
   logic        reset;
   int          error_count;
   int          outstanding;
   int unsigned cycle_count = 0;

   // When set, neither the sender nor the receiver inserts idle cycles.
   bit          no_idle = 1'b0;

   // Row that the next tick will be scanned on, tracked from the transfers we make.
   logic [kmes_pkg::ROW_WIDTH-1:0] scan_row = kmes_pkg::ROW_TOP;

   kmes_req_if req_ch();
   kmes_rsp_if rsp_ch();

   key_matrix_and_encoder_scanner i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   kmes_scan_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog. Ending here always counts as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Idle cycles before one transfer, drawn afresh for every item on either side.
   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   // Builds the raw column word for an encoder row. The scanner reverses the column
   // order, so the quadrature pair sits in raw bits 4 and 3 and the push key in bit 2.
   // The two remaining bits are ignored on that row and carry random filler.
   function automatic logic [kmes_pkg::COL_WIDTH-1:0] encoder_columns(
      input logic [1:0] pair, input logic push);
      logic [1:0] filler;
      filler = 2'($urandom);
      return {pair[0], pair[1], push, filler};
   endfunction

   // Offers one scan tick and returns at the clock edge on which it is transferred.
   // Valid stays high after the transfer so back-to-back ticks need no extra edge.
   task automatic send_tick(input logic [kmes_pkg::COL_WIDTH-1:0] cols, input logic clear);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.column_bits   <= cols;
      req_ch.clear_latches <= clear;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      case (scan_row)
         kmes_pkg::ROW_TOP:    scan_row = kmes_pkg::ROW_BOTTOM;
         kmes_pkg::ROW_BOTTOM: scan_row = kmes_pkg::ROW_ENCODER;
         default:              scan_row = kmes_pkg::ROW_TOP;
      endcase
   endtask

   // Stops offering ticks until every result that is owed has been collected.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Reset is applied once, at the start of the run.
   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.column_bits   <= '0;
      req_ch.clear_latches <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Result receiver. It stalls a random number of cycles before each transfer, or
   // not at all while no_idle is set, so back pressure lands on every phase of the
   // scanner's single result register.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Stimulus.
   initial begin
      logic [kmes_pkg::COL_WIDTH-1:0] top_keys;
      logic [kmes_pkg::COL_WIDTH-1:0] bottom_keys;
      logic [kmes_pkg::COL_WIDTH-1:0] cols;
      logic [1:0]                     gray_pos;
      logic [1:0]                     pair;
      logic [1:0]                     noise;
      logic                           push;
      int                             pick;

      top_keys    = '0;
      bottom_keys = '0;
      gray_pos    = '0;
      push        = 1'b0;
      do @(posedge clock); while (reset);

      // Directed part. Ticks go top, bottom, encoder from reset, so each group below
      // is one full pass over the three rows.
      // Every key pressed at once; the history picks up 11 without a step.
      send_tick(5'h1f, 1'b0); send_tick(5'h1f, 1'b0);
      send_tick(encoder_columns(2'b11, 1'b1), 1'b0);
      // Everything released, with a clear on the first tick of the pass.
      send_tick(5'h00, 1'b1); send_tick(5'h00, 1'b0);
      send_tick(encoder_columns(2'b00, 1'b0), 1'b0);
      // Alternating column patterns expose any slip in the bit reversal.
      send_tick(5'h15, 1'b0); send_tick(5'h0a, 1'b0);
      send_tick(encoder_columns(2'b10, 1'b0), 1'b0);
      // Pair 10 then 11 completes the right step pattern.
      send_tick(5'h0a, 1'b1); send_tick(5'h15, 1'b0);
      send_tick(encoder_columns(2'b11, 1'b1), 1'b0);
      // Clear on the encoder row: only the push key bit can be latched on that tick.
      send_tick(5'h00, 1'b0); send_tick(5'h1f, 1'b1);
      send_tick(encoder_columns(2'b01, 1'b0), 1'b1);
      // Pair 01 then 11 completes the left step pattern.
      send_tick(5'h1f, 1'b0); send_tick(5'h00, 1'b0);
      send_tick(encoder_columns(2'b11, 1'b1), 1'b0);
      // A clear on every tick of a pass.
      send_tick(5'h00, 1'b1); send_tick(5'h00, 1'b1);
      send_tick(encoder_columns(2'b11, 1'b0), 1'b1);

      // Hold off the sender until every result is back before going random.
      drain();

      // Random part. Key rows hold their pattern about half the time so presses and
      // releases stay meaningful. Encoder rows mostly walk the Gray sequence in either
      // direction, which produces steps; one pick in ten is noise.
      // Every third block runs without idling on either side.
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         no_idle = (blk % 3 == 2);
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            if (scan_row == kmes_pkg::ROW_ENCODER) begin
               pick  = $urandom_range(0, 9);
               noise = 2'($urandom);
               if (pick < 4) begin
                  gray_pos = gray_pos + 1'b1;
               end else if (pick < 8) begin
                  gray_pos = gray_pos - 1'b1;
               end
               pair = (pick == 9) ? noise : {gray_pos[1], gray_pos[1] ^ gray_pos[0]};
               if ($urandom_range(0, 3) == 0) push = ~push;
               cols = encoder_columns(pair, push);
            end else begin
               if ($urandom_range(0, 1) == 1) begin
                  if (scan_row == kmes_pkg::ROW_TOP) begin
                     top_keys = kmes_pkg::COL_WIDTH'($urandom);
                  end else begin
                     bottom_keys = kmes_pkg::COL_WIDTH'($urandom);
                  end
               end
               cols = (scan_row == kmes_pkg::ROW_TOP) ? top_keys : bottom_keys;
            end
            send_tick(cols, $urandom_range(0, 7) == 0);
         end
         if (blk == RANDOM_BLOCKS / 2) drain();
      end

      // Wait for the last results, then a few cycles more for anything stray.
      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ key_matrix_and_encoder_scanner.f @@
src/kmes_pkg.sv
src/kmes_if.sv
src/key_matrix_and_encoder_scanner.sv
test/kmes_scan_checker.sv
test/tb_top.sv
